/* rtl/dea_pkg.sv */
// Shared widths, register indexes and types for the decimated exponential average filter.
// Used by the top level and by the serial divider; depends on nothing.
package dea_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int CFG_W     = 16;
  localparam int PROD_W    = SAMPLE_W + CFG_W;
  localparam int TIMER_W   = 2 * CFG_W;
  localparam int MUL_CNT_W = $clog2(CFG_W);

  // The timer reload is the product of the two registers divided by this constant.
  localparam int TIMER_DIV_W = 5;
  localparam logic [TIMER_DIV_W-1:0] TIMER_DIVISOR = 5'd25;

  localparam logic REG_FILTER_TIME = 1'b0;
  localparam logic REG_KERNEL_RATE = 1'b1;

  localparam logic [CFG_W-1:0] FILTER_TIME_RESET = 16'd1;
  localparam logic [CFG_W-1:0] KERNEL_RATE_RESET = 16'd100;

  // Status of one serial divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/decimated_exponential_average_filter.sv */
// Decimated exponential average filter: a tick that is disabled, cleared or still counting
// down passes through S_DONE into the output register after its request is accepted. A tick
// that runs the average passes through a bit-serial multiply ((N-1)*held and
// filter_time*kernel_rate side by side), a step that forms the numerator and starts the
// dividers, the one-bit-per-cycle divider for the 48-by-16 average (the reload division by
// 25 runs alongside it and ends sooner), a step that takes the quotient, then a step that
// posts the result. A result waits while the previous one is still stalled in the output
// register. A new request is taken as soon as the result sits in the output register, even
// if the receiver is still stalling it. Depends on dea_pkg and dea_div.
module decimated_exponential_average_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [dea_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dea_pkg::SAMPLE_W-1:0]  sample,
  input  logic                          enable,
  input  logic                          clear,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dea_pkg::SAMPLE_W-1:0]  filtered,
  output logic                          updated
);

  localparam int SW = dea_pkg::SAMPLE_W;
  localparam int CW = dea_pkg::CFG_W;
  localparam int PW = dea_pkg::PROD_W;
  localparam int TW = dea_pkg::TIMER_W;
  localparam logic [dea_pkg::MUL_CNT_W-1:0] MUL_LAST = dea_pkg::MUL_CNT_W'(CW - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;

  logic [CW-1:0] filter_time;
  logic [CW-1:0] kernel_rate;
  logic [TW-1:0] tick_timer;
  logic [SW-1:0] held_output;

  logic [SW-1:0] sample_q;
  logic [PW-1:0] mul_prod;
  logic [CW-1:0] mul_bits;
  logic [TW-1:0] rel_prod;
  logic [CW-1:0] rel_bits;
  logic [dea_pkg::MUL_CNT_W-1:0] mul_cnt;
  logic [SW-1:0] res_value;
  logic          res_updated;

  logic [SW:0]   main_sum;
  logic [CW:0]   rel_sum;
  logic          in_accept;
  logic          div_start;
  logic [PW-1:0] main_num;
  logic [PW-1:0] main_quo;
  logic [TW-1:0] tim_quo;
  dea_pkg::div_stat_t main_stat;
  dea_pkg::div_stat_t tim_stat;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign div_start = (state == S_LOAD);
  assign main_num  = mul_prod + {{CW{1'b0}}, sample_q};

  // Right-shifting shift-and-add: one multiplier bit per cycle.
  always_comb begin
    main_sum = {1'b0, mul_prod[PW-1:CW]} + (mul_bits[0] ? {1'b0, held_output} : '0);
    rel_sum  = {1'b0, rel_prod[TW-1:CW]} + (rel_bits[0] ? {1'b0, kernel_rate} : '0);
  end

  dea_div #(
    .NUM_W(PW),
    .DEN_W(CW)
  ) u_div_main (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (main_num),
    .den  (mul_bits),
    .quo  (main_quo),
    .stat (main_stat)
  );

  dea_div #(
    .NUM_W(TW),
    .DEN_W(dea_pkg::TIMER_DIV_W)
  ) u_div_timer (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (rel_prod),
    .den  (dea_pkg::TIMER_DIVISOR),
    .quo  (tim_quo),
    .stat (tim_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      filter_time <= dea_pkg::FILTER_TIME_RESET;
      kernel_rate <= dea_pkg::KERNEL_RATE_RESET;
      tick_timer  <= '0;
      held_output <= '0;
      out_valid   <= 1'b0;
      mul_cnt     <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          dea_pkg::REG_FILTER_TIME: filter_time <= cfg_data;
          dea_pkg::REG_KERNEL_RATE: kernel_rate <= cfg_data;
          default: ;
        endcase
      end

      // In S_DONE the output register is handled by the posting step below.
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            res_updated <= 1'b0;
            if (!enable || clear) begin
              held_output <= sample;
              tick_timer  <= '0;
              res_value   <= sample;
              state       <= S_DONE;
            end else if (tick_timer != '0) begin
              tick_timer <= tick_timer - 1'b1;
              res_value  <= held_output;
              state      <= S_DONE;
            end else begin
              // N-1 doubles as the multiplier; the divider later takes N itself.
              sample_q <= sample;
              mul_bits <= (filter_time == '0) ? '0 : filter_time - 1'b1;
              rel_bits <= filter_time;
              mul_prod <= '0;
              rel_prod <= '0;
              mul_cnt  <= '0;
              state    <= S_MUL;
            end
          end
        end
        S_MUL: begin
          mul_prod <= {main_sum, mul_prod[CW-1:1]};
          rel_prod <= {rel_sum, rel_prod[CW-1:1]};
          rel_bits <= {1'b0, rel_bits[CW-1:1]};
          mul_cnt  <= mul_cnt + 1'b1;
          if (mul_cnt == MUL_LAST) begin
            // Restore the divisor N after the shifts emptied the multiplier.
            mul_bits <= (filter_time == '0) ? CW'(1) : filter_time;
            state    <= S_LOAD;
          end else begin
            mul_bits <= {1'b0, mul_bits[CW-1:1]};
          end
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (main_stat.done) begin
            held_output <= main_quo[SW-1:0];
            tick_timer  <= tim_quo;
            res_value   <= main_quo[SW-1:0];
            res_updated <= 1'b1;
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            filtered  <= res_value;
            updated   <= res_updated;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The reload division is shorter, so it must be finished when the average is.
  a_timer_div_first: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && main_stat.done) |-> !tim_stat.busy)
    else $error("timer reload divider still busy when average finished");

  a_div_idle_in_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (!main_stat.busy && !tim_stat.busy))
    else $error("divider busy during multiply phase");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state != S_IDLE))
    else $error("accepted request did not start processing");

  a_update_only_from_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && $past(state) == S_DIV) |-> res_updated)
    else $error("averaging result posted without update flag");

endmodule

/* rtl/dea_div.sv */
// Restoring divider that retires one quotient bit per cycle.
// Uses dea_pkg for its status struct.
module dea_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  output logic [NUM_W-1:0]    quo,
  output dea_pkg::div_stat_t  stat
);

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W+1:0] trial;
  logic [DEN_W:0]   shifted;

  always_comb begin
    shifted = {rem, quo[NUM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST);
      if (busy) begin
        // A non-negative trial means this quotient bit is one.
        if (!trial[DEN_W+1]) begin
          rem <= trial[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= shifted[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end else if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        quo   <= num;
        den_q <= den;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
